[rtl/core/ecr_pkg.sv]
// Shared types and widths for the two-dimensional elastic collision pipeline.
`default_nettype none
package ecr_pkg;

    localparam int WORD_BITS = 24;
    localparam int DIFF_BITS = WORD_BITS + 1;
    localparam int NORM_BITS = 14;
    localparam int LEAD_BITS = $clog2(WORD_BITS);
    localparam int VEC_BITS  = NORM_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + VEC_BITS;
    localparam int DOT_BITS  = PROD_BITS + 1;
    localparam int DMAG_BITS = PROD_BITS;
    localparam int SQ_BITS   = 2 * NORM_BITS;
    localparam int EE_BITS   = SQ_BITS + 1;
    localparam int MASS_BITS = WORD_BITS;
    localparam int TOT_BITS  = WORD_BITS + 1;
    localparam int DEN0_BITS = TOT_BITS + EE_BITS;
    localparam int PA_BITS   = MASS_BITS + NORM_BITS;
    localparam int HALF_BITS = DMAG_BITS / 2;
    localparam int PP_BITS   = PA_BITS + HALF_BITS;
    localparam int NUM_BITS  = PA_BITS + DMAG_BITS;
    localparam int DVD_BITS  = NUM_BITS + 3;
    localparam int DVS_BITS  = DEN0_BITS + 1;
    localparam int QUO_BITS  = DVD_BITS - DVS_BITS + 1;
    localparam int LANES     = 4;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] first_pos_x;
        logic signed [WORD_BITS-1:0] first_pos_y;
        logic signed [WORD_BITS-1:0] second_pos_x;
        logic signed [WORD_BITS-1:0] second_pos_y;
        logic signed [WORD_BITS-1:0] first_vel_x;
        logic signed [WORD_BITS-1:0] first_vel_y;
        logic signed [WORD_BITS-1:0] second_vel_x;
        logic signed [WORD_BITS-1:0] second_vel_y;
        logic        [WORD_BITS-1:0] first_mass;
        logic        [WORD_BITS-1:0] second_mass;
        logic                        first_fixed;
        logic                        second_fixed;
    } t_in_req;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] new_first_vel_x;
        logic signed [WORD_BITS-1:0] new_first_vel_y;
        logic signed [WORD_BITS-1:0] new_second_vel_x;
        logic signed [WORD_BITS-1:0] new_second_vel_y;
        logic                        degenerate;
    } t_out_req;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] v1x;
        logic signed [WORD_BITS-1:0] v1y;
        logic signed [WORD_BITS-1:0] v2x;
        logic signed [WORD_BITS-1:0] v2y;
        logic                        apply1;
        logic                        apply2;
        logic                        degen;
    } t_side;

    typedef struct packed {
        logic [DMAG_BITS-1:0] dot_mag;
        logic                 dot_neg;
        logic [NORM_BITS-1:0] ex_mag;
        logic [NORM_BITS-1:0] ey_mag;
        logic                 ex_neg;
        logic                 ey_neg;
        logic [EE_BITS-1:0]   ee;
        logic [MASS_BITS-1:0] fnum1;
        logic [MASS_BITS-1:0] fnum2;
        logic [TOT_BITS-1:0]  fden;
        t_side                side;
    } t_geo;

    typedef struct packed {
        logic [LANES-1:0][DVD_BITS-1:0] num;
        logic [DVS_BITS-1:0]            den;
        logic [LANES-1:0]               neg;
        t_side                          side;
    } t_div_req;

endpackage
`default_nettype wire

[rtl/core/ecr_geom.sv]
// Direction normalisation, dot product and squared length, in five stages.
`default_nettype none
module ecr_geom
    import ecr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_in_req i_req,
    output logic         o_ready,
    output logic         o_valid,
    output t_geo         o_geo,
    input  wire logic    i_ready
);

    typedef struct packed {
        logic signed [DIFF_BITS-1:0] dx;
        logic signed [DIFF_BITS-1:0] dy;
        logic signed [DIFF_BITS-1:0] wx;
        logic signed [DIFF_BITS-1:0] wy;
        logic [MASS_BITS-1:0]        fnum1;
        logic [MASS_BITS-1:0]        fnum2;
        logic [TOT_BITS-1:0]         fden;
        t_side                       side;
    } t_g1;

    typedef struct packed {
        logic [WORD_BITS-1:0]        ax;
        logic [WORD_BITS-1:0]        ay;
        logic                        sx;
        logic                        sy;
        logic [LEAD_BITS-1:0]        lead;
        logic signed [DIFF_BITS-1:0] wx;
        logic signed [DIFF_BITS-1:0] wy;
        logic [MASS_BITS-1:0]        fnum1;
        logic [MASS_BITS-1:0]        fnum2;
        logic [TOT_BITS-1:0]         fden;
        t_side                       side;
    } t_g2;

    typedef struct packed {
        logic signed [VEC_BITS-1:0]  ex;
        logic signed [VEC_BITS-1:0]  ey;
        logic signed [DIFF_BITS-1:0] wx;
        logic signed [DIFF_BITS-1:0] wy;
        logic [MASS_BITS-1:0]        fnum1;
        logic [MASS_BITS-1:0]        fnum2;
        logic [TOT_BITS-1:0]         fden;
        t_side                       side;
    } t_g3;

    typedef struct packed {
        logic signed [PROD_BITS-1:0] pwx;
        logic signed [PROD_BITS-1:0] pwy;
        logic [SQ_BITS-1:0]          pxx;
        logic [SQ_BITS-1:0]          pyy;
        logic signed [VEC_BITS-1:0]  ex;
        logic signed [VEC_BITS-1:0]  ey;
        logic [MASS_BITS-1:0]        fnum1;
        logic [MASS_BITS-1:0]        fnum2;
        logic [TOT_BITS-1:0]         fden;
        t_side                       side;
    } t_g4;

    localparam int STAGES = 5;

    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] rdy;
    t_g1  r_g1, n_g1;
    t_g2  r_g2, n_g2;
    t_g3  r_g3, n_g3;
    t_g4  r_g4, n_g4;
    t_geo r_g5, n_g5;

    always_comb begin
        rdy[STAGES-1] = !r_v[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[STAGES-1];
    assign o_geo   = r_g5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) begin
                if (rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Stage one: differences, total mass and the case selection.
    always_comb begin
        logic [TOT_BITS-1:0] tot;
        logic                moving;
        logic signed [DIFF_BITS-1:0] p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y;
        p1x = DIFF_BITS'(i_req.first_pos_x);
        p1y = DIFF_BITS'(i_req.first_pos_y);
        p2x = DIFF_BITS'(i_req.second_pos_x);
        p2y = DIFF_BITS'(i_req.second_pos_y);
        v1x = DIFF_BITS'(i_req.first_vel_x);
        v1y = DIFF_BITS'(i_req.first_vel_y);
        v2x = DIFF_BITS'(i_req.second_vel_x);
        v2y = DIFF_BITS'(i_req.second_vel_y);
        tot = TOT_BITS'(i_req.first_mass) + TOT_BITS'(i_req.second_mass);
        moving = !i_req.first_fixed && !i_req.second_fixed;
        n_g1.dx = p2x - p1x;
        n_g1.dy = p2y - p1y;
        if (moving) begin
            n_g1.wx = v2x - v1x;
            n_g1.wy = v2y - v1y;
        end else if (i_req.first_fixed) begin
            n_g1.wx = v2x;
            n_g1.wy = v2y;
        end else begin
            n_g1.wx = -v1x;
            n_g1.wy = -v1y;
        end
        n_g1.fnum1 = moving ? i_req.second_mass : MASS_BITS'(1);
        n_g1.fnum2 = moving ? i_req.first_mass : MASS_BITS'(1);
        n_g1.fden  = moving ? tot : TOT_BITS'(1);
        n_g1.side.v1x = i_req.first_vel_x;
        n_g1.side.v1y = i_req.first_vel_y;
        n_g1.side.v2x = i_req.second_vel_x;
        n_g1.side.v2y = i_req.second_vel_y;
        n_g1.side.degen = (n_g1.dx == '0 && n_g1.dy == '0) || tot == '0;
        n_g1.side.apply1 = !n_g1.side.degen && !i_req.first_fixed;
        n_g1.side.apply2 = !n_g1.side.degen && !i_req.second_fixed;
    end

    // Stage two: magnitudes and the leading one of the larger one.
    always_comb begin
        logic [DIFF_BITS-1:0] ax, ay;
        logic [WORD_BITS-1:0] mx;
        ax = r_g1.dx[DIFF_BITS-1] ? DIFF_BITS'(-r_g1.dx) : DIFF_BITS'(r_g1.dx);
        ay = r_g1.dy[DIFF_BITS-1] ? DIFF_BITS'(-r_g1.dy) : DIFF_BITS'(r_g1.dy);
        n_g2.ax = ax[WORD_BITS-1:0];
        n_g2.ay = ay[WORD_BITS-1:0];
        n_g2.sx = r_g1.dx[DIFF_BITS-1];
        n_g2.sy = r_g1.dy[DIFF_BITS-1];
        mx = (n_g2.ax > n_g2.ay) ? n_g2.ax : n_g2.ay;
        n_g2.lead = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (mx[b]) n_g2.lead = LEAD_BITS'(b);
        end
        n_g2.wx    = r_g1.wx;
        n_g2.wy    = r_g1.wy;
        n_g2.fnum1 = r_g1.fnum1;
        n_g2.fnum2 = r_g1.fnum2;
        n_g2.fden  = r_g1.fden;
        n_g2.side  = r_g1.side;
    end

    // Stage three: shift so that the larger magnitude has its top bit at NORM_BITS-1.
    always_comb begin
        logic [WORD_BITS-1:0] sx_m, sy_m;
        logic [LEAD_BITS-1:0] amt;
        if (r_g2.lead >= LEAD_BITS'(NORM_BITS - 1)) begin
            amt  = r_g2.lead - LEAD_BITS'(NORM_BITS - 1);
            sx_m = r_g2.ax >> amt;
            sy_m = r_g2.ay >> amt;
        end else begin
            amt  = LEAD_BITS'(NORM_BITS - 1) - r_g2.lead;
            sx_m = r_g2.ax << amt;
            sy_m = r_g2.ay << amt;
        end
        n_g3.ex = r_g2.sx ? -$signed({1'b0, sx_m[NORM_BITS-1:0]})
                          : $signed({1'b0, sx_m[NORM_BITS-1:0]});
        n_g3.ey = r_g2.sy ? -$signed({1'b0, sy_m[NORM_BITS-1:0]})
                          : $signed({1'b0, sy_m[NORM_BITS-1:0]});
        n_g3.wx    = r_g2.wx;
        n_g3.wy    = r_g2.wy;
        n_g3.fnum1 = r_g2.fnum1;
        n_g3.fnum2 = r_g2.fnum2;
        n_g3.fden  = r_g2.fden;
        n_g3.side  = r_g2.side;
    end

    // Stage four: products.
    always_comb begin
        logic signed [2*VEC_BITS-1:0] sqx, sqy;
        n_g4.pwx = r_g3.wx * r_g3.ex;
        n_g4.pwy = r_g3.wy * r_g3.ey;
        sqx = r_g3.ex * r_g3.ex;
        sqy = r_g3.ey * r_g3.ey;
        n_g4.pxx   = sqx[SQ_BITS-1:0];
        n_g4.pyy   = sqy[SQ_BITS-1:0];
        n_g4.ex    = r_g3.ex;
        n_g4.ey    = r_g3.ey;
        n_g4.fnum1 = r_g3.fnum1;
        n_g4.fnum2 = r_g3.fnum2;
        n_g4.fden  = r_g3.fden;
        n_g4.side  = r_g3.side;
    end

    // Stage five: sums and sign-magnitude split.
    always_comb begin
        logic signed [DOT_BITS-1:0] dot;
        logic [DOT_BITS-1:0]        dmag;
        logic [VEC_BITS-1:0]        axm, aym;
        dot  = r_g4.pwx + r_g4.pwy;
        dmag = dot[DOT_BITS-1] ? DOT_BITS'(-dot) : DOT_BITS'(dot);
        axm  = r_g4.ex[VEC_BITS-1] ? VEC_BITS'(-r_g4.ex) : VEC_BITS'(r_g4.ex);
        aym  = r_g4.ey[VEC_BITS-1] ? VEC_BITS'(-r_g4.ey) : VEC_BITS'(r_g4.ey);
        n_g5.dot_mag = dmag[DMAG_BITS-1:0];
        n_g5.dot_neg = dot[DOT_BITS-1];
        n_g5.ex_mag  = axm[NORM_BITS-1:0];
        n_g5.ey_mag  = aym[NORM_BITS-1:0];
        n_g5.ex_neg  = r_g4.ex[VEC_BITS-1];
        n_g5.ey_neg  = r_g4.ey[VEC_BITS-1];
        n_g5.ee      = EE_BITS'(r_g4.pxx) + EE_BITS'(r_g4.pyy);
        n_g5.fnum1   = r_g4.fnum1;
        n_g5.fnum2   = r_g4.fnum2;
        n_g5.fden    = r_g4.fden;
        n_g5.side    = r_g4.side;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) r_g1 <= n_g1;
        if (rdy[1]) r_g2 <= n_g2;
        if (rdy[2]) r_g3 <= n_g3;
        if (rdy[3]) r_g4 <= n_g4;
        if (rdy[4]) r_g5 <= n_g5;
    end

endmodule
`default_nettype wire

[rtl/core/ecr_scale.sv]
// Dividend and divisor formation for the four corrections, in three stages.
`default_nettype none
module ecr_scale
    import ecr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_geo i_geo,
    output logic      o_ready,
    output logic      o_valid,
    output t_div_req  o_div,
    input  wire logic i_ready
);

    typedef struct packed {
        logic [DEN0_BITS-1:0]          den0;
        logic [LANES-1:0][PA_BITS-1:0] pa;
        logic [DMAG_BITS-1:0]          dot_mag;
        logic [LANES-1:0]              neg;
        t_side                         side;
    } t_s1;

    typedef struct packed {
        logic [DEN0_BITS-1:0]          den0;
        logic [LANES-1:0][PP_BITS-1:0] plo;
        logic [LANES-1:0][PP_BITS-1:0] phi;
        logic [LANES-1:0]              neg;
        t_side                         side;
    } t_s2;

    localparam int STAGES = 3;

    logic [STAGES-1:0] rdy;
    logic [STAGES-1:0] r_v;
    t_s1      r_s1, n_s1;
    t_s2      r_s2, n_s2;
    t_div_req r_s3, n_s3;

    always_comb begin
        rdy[STAGES-1] = !r_v[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[STAGES-1];
    assign o_div   = r_s3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) begin
                if (rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Lanes are first x, first y, second x, second y.
    always_comb begin
        n_s1.den0  = i_geo.fden * i_geo.ee;
        n_s1.pa[0] = i_geo.fnum1 * i_geo.ex_mag;
        n_s1.pa[1] = i_geo.fnum1 * i_geo.ey_mag;
        n_s1.pa[2] = i_geo.fnum2 * i_geo.ex_mag;
        n_s1.pa[3] = i_geo.fnum2 * i_geo.ey_mag;
        n_s1.neg[0] = i_geo.dot_neg ^ i_geo.ex_neg;
        n_s1.neg[1] = i_geo.dot_neg ^ i_geo.ey_neg;
        n_s1.neg[2] = !i_geo.dot_neg ^ i_geo.ex_neg;
        n_s1.neg[3] = !i_geo.dot_neg ^ i_geo.ey_neg;
        n_s1.dot_mag = i_geo.dot_mag;
        n_s1.side    = i_geo.side;
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_s2.plo[l] = r_s1.pa[l] * r_s1.dot_mag[HALF_BITS-1:0];
            n_s2.phi[l] = r_s1.pa[l] * r_s1.dot_mag[DMAG_BITS-1:HALF_BITS];
        end
        n_s2.den0 = r_s1.den0;
        n_s2.neg  = r_s1.neg;
        n_s2.side = r_s1.side;
    end

    // Rounding to nearest: floor((4*num + den) / (2*den)).
    always_comb begin
        logic [NUM_BITS-1:0] num;
        for (int l = 0; l < LANES; l++) begin
            num = (NUM_BITS'(r_s2.phi[l]) << HALF_BITS) + NUM_BITS'(r_s2.plo[l]);
            n_s3.num[l] = DVD_BITS'({num, 2'b00}) + DVD_BITS'(r_s2.den0);
        end
        n_s3.den  = {r_s2.den0, 1'b0};
        n_s3.neg  = r_s2.neg;
        n_s3.side = r_s2.side;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) r_s1 <= n_s1;
        if (rdy[1]) r_s2 <= n_s2;
        if (rdy[2]) r_s3 <= n_s3;
    end

endmodule
`default_nettype wire

[rtl/core/ecr_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with the final add and clamp.
`default_nettype none
module ecr_div
    import ecr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_div_req i_div,
    output logic          o_ready,
    output logic          o_valid,
    output t_out_req      o_rsp,
    input  wire logic     i_stall
);

    typedef struct packed {
        logic [LANES-1:0][DVD_BITS-1:0] rem;
        logic [LANES-1:0][QUO_BITS-1:0] quo;
        logic [DVS_BITS-1:0]            den;
        logic [LANES-1:0]               neg;
        t_side                          side;
    } t_dstage;

    logic [QUO_BITS-1:0] r_v;
    logic [QUO_BITS:0]   rdy;
    t_dstage             r_st [QUO_BITS];
    t_dstage             s_in [QUO_BITS];
    t_dstage             n_st [QUO_BITS];
    logic                r_ov;
    t_out_req            r_rsp, n_rsp;

    function automatic logic signed [WORD_BITS-1:0] apply_corr(
        input logic signed [WORD_BITS-1:0] v,
        input logic [QUO_BITS-1:0]         q,
        input logic                        neg,
        input logic                        en
    );
        logic signed [QUO_BITS:0]    corr;
        logic signed [QUO_BITS+1:0]  sum;
        logic signed [QUO_BITS+1:0]  vx;
        logic signed [WORD_BITS-1:0] res;
        corr = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
        vx   = (QUO_BITS+2)'(v);
        sum  = vx + corr;
        if (sum[QUO_BITS+1:WORD_BITS-1] == '0 || sum[QUO_BITS+1:WORD_BITS-1] == '1) begin
            res = sum[WORD_BITS-1:0];
        end else if (sum[QUO_BITS+1]) begin
            res = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        return en ? res : v;
    endfunction

    always_comb begin
        rdy[QUO_BITS] = !r_ov || !i_stall;
        for (int k = QUO_BITS - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_ov;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            if (rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < QUO_BITS; k++) begin
                if (rdy[k]) r_v[k] <= r_v[k-1];
            end
            if (rdy[QUO_BITS]) r_ov <= r_v[QUO_BITS-1];
        end
    end

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        if (k == 0) begin : g_head
            always_comb begin
                s_in[k].rem  = i_div.num;
                s_in[k].quo  = '0;
                s_in[k].den  = i_div.den;
                s_in[k].neg  = i_div.neg;
                s_in[k].side = i_div.side;
            end
        end else begin : g_body
            assign s_in[k] = r_st[k-1];
        end

        always_comb begin
            logic [DVD_BITS-1:0] sub;
            n_st[k] = s_in[k];
            sub = DVD_BITS'(s_in[k].den) << (QUO_BITS - 1 - k);
            for (int l = 0; l < LANES; l++) begin
                if (s_in[k].rem[l] >= sub) begin
                    n_st[k].rem[l] = s_in[k].rem[l] - sub;
                    n_st[k].quo[l][QUO_BITS-1-k] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k]) r_st[k] <= n_st[k];
        end
    end

    always_comb begin
        t_dstage f;
        f = r_st[QUO_BITS-1];
        n_rsp.new_first_vel_x  = apply_corr(f.side.v1x, f.quo[0], f.neg[0], f.side.apply1);
        n_rsp.new_first_vel_y  = apply_corr(f.side.v1y, f.quo[1], f.neg[1], f.side.apply1);
        n_rsp.new_second_vel_x = apply_corr(f.side.v2x, f.quo[2], f.neg[2], f.side.apply2);
        n_rsp.new_second_vel_y = apply_corr(f.side.v2y, f.quo[3], f.neg[3], f.side.apply2);
        n_rsp.degenerate       = f.side.degen;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[QUO_BITS]) r_rsp <= n_rsp;
    end

endmodule
`default_nettype wire

[rtl/core/elastic_collision_response_2d.sv]
// Top level of the two-dimensional elastic collision response pipeline.
`default_nettype none
// One colliding pair enters per cycle while o_stall is low, and its new velocities
// leave after five stages of geometry, three of multiplication and 28 of division
// and output. The latency is set by the restoring divider, which retires one
// quotient bit per stage for all four velocity corrections at once. A stall
// on the output holds only the stages that are full, so bubbles close up and
// the block keeps taking requests until every stage holds one.
module elastic_collision_response_2d
    import ecr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_in_req i_req,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_out_req     o_rsp
);

    logic     geo_valid, geo_ready;
    t_geo     geo;
    logic     div_valid, div_ready;
    t_div_req div;
    logic     in_ready;

    ecr_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_ready (in_ready),
        .o_valid (geo_valid),
        .o_geo   (geo),
        .i_ready (geo_ready)
    );

    ecr_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (geo_valid),
        .i_geo   (geo),
        .o_ready (geo_ready),
        .o_valid (div_valid),
        .o_div   (div),
        .i_ready (div_ready)
    );

    ecr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .i_div   (div),
        .o_ready (div_ready),
        .o_valid (o_valid),
        .o_rsp   (o_rsp),
        .i_stall (i_stall)
    );

    assign o_stall = !in_ready;

endmodule
`default_nettype wire

[rtl/core/ecr_checker.sv]
// Port-level checks for the collision response block and their binding.
`default_nettype none
module ecr_checker
    import ecr_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_stall,
    input wire logic     o_valid,
    input wire logic     i_stall,
    input wire t_out_req o_rsp
);

    // A held result must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");

    // The input side only stalls when the output is full and stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without an output stall");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

endmodule

bind elastic_collision_response_2d ecr_checker u_ecr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);
`default_nettype wire
